/* sv/multilinear_table_interp_defines.svh */
// ----------------------------------------------------------------------------
// multilinear_table_interp_defines
// Assertion macros shared by the interpolation table modules.
// ----------------------------------------------------------------------------
`ifndef MULTILINEAR_TABLE_INTERP_DEFINES_SVH
`define MULTILINEAR_TABLE_INTERP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MTI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mti assertion failed");

// Next-cycle implication, checked outside reset
`define MTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mti assertion failed");

`endif

/* sv/mti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_pkg
// Types and constants of the multilinear interpolation table.
// ----------------------------------------------------------------------------
package mti_pkg;

	localparam int MAX_DIMS   = 6;
	localparam int MAX_BP     = 16;
	localparam int GRID_DEPTH = 4096;
	localparam int BP_DEPTH   = MAX_DIMS * MAX_BP;

	// Q1.16 fraction, 0x10000 is 1.0
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// Action codes
	localparam logic [1:0] ACT_BP_WR   = 2'd0;
	localparam logic [1:0] ACT_GRID_WR = 2'd1;
	localparam logic [1:0] ACT_LOOKUP  = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
	localparam logic [2:0] REG_BP_COUNT_0 = 3'd1;
	localparam logic [2:0] REG_BP_COUNT_5 = 3'd6;
	localparam logic [2:0] REG_DATA_COUNT = 3'd7;

	typedef struct packed {
		logic        [1:0]  action;
		logic        [2:0]  dim;
		logic        [11:0] index;
		logic signed [31:0] value;
		logic signed [31:0] coord_0;
		logic signed [31:0] coord_1;
		logic signed [31:0] coord_2;
		logic signed [31:0] coord_3;
		logic signed [31:0] coord_4;
		logic signed [31:0] coord_5;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               saturated;
	} out_item_t;

	// Saturated configuration as used by the datapath
	typedef struct packed {
		logic [2:0]                   num_dims;
		logic [MAX_DIMS-1:0][4:0]     bp_count;
		logic [12:0]                  data_count;
	} cfg_t;

	typedef logic [MAX_DIMS-1:0][31:0] coord_vec_t;
	typedef logic [MAX_DIMS-1:0][3:0]  lo_vec_t;
	typedef logic [MAX_DIMS-1:0][16:0] fr_vec_t;

endpackage

/* sv/mti_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_div
// Restoring divider for the Q1.16 fraction floor(dx * 65536 / gap), dx <= gap.
// ----------------------------------------------------------------------------
module mti_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dx,
	input  logic [31:0] gap,
	output logic        done,
	output logic [16:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] gap_q;
	logic [16:0] quot_q;
	logic [32:0] trial;
	logic        ge;

	// First step compares dx itself, later steps shift in a zero
	always_comb begin
		trial = (cnt_q == 5'd0) ? rem_q : {rem_q[31:0], 1'b0};
		ge    = trial >= {1'b0, gap_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, dx};
			gap_q  <= gap;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? trial - {1'b0, gap_q} : trial;
			quot_q <= {quot_q[15:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* sv/mti_locate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_locate
// Breakpoint memory and per-dimension search: lower index and fraction.
// ----------------------------------------------------------------------------
`include "multilinear_table_interp_defines.svh"

module mti_locate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bp_we,
	input  logic [6:0]          bp_waddr,
	input  logic signed [31:0]  bp_wdata,
	input  logic                start,
	input  mti_pkg::cfg_t       cfg,
	input  mti_pkg::coord_vec_t coords,
	output logic                done,
	output mti_pkg::lo_vec_t    lo_vec,
	output mti_pkg::fr_vec_t    fr_vec
);

	typedef enum logic [2:0] {
		L_IDLE, L_DIM, L_FIRST, L_LAST, L_SCAN, L_DIV
	} lstate_t;

	lstate_t            state_q;
	logic [2:0]         d_q;
	logic [3:0]         i_q;
	logic signed [31:0] prev_q;
	logic               done_q;
	mti_pkg::lo_vec_t   lo_q;
	mti_pkg::fr_vec_t   fr_q;

	logic signed [31:0] bp_mem [mti_pkg::BP_DEPTH];
	logic signed [31:0] rdata_q;
	logic [6:0]         rd_addr;

	logic signed [31:0] x;
	logic [4:0]         cnt;
	logic [3:0]         nm1;
	logic signed [32:0] gap_w;
	logic signed [32:0] dx_w;
	logic               hit;
	logic               div_start;
	logic               div_done;
	logic [16:0]        div_q;

	// Current dimension's operands and the next read address
	always_comb begin
		x         = $signed(coords[d_q]);
		cnt       = cfg.bp_count[d_q];
		nm1       = 4'(cnt - 5'd1);
		gap_w     = {rdata_q[31], rdata_q} - {prev_q[31], prev_q};
		dx_w      = {x[31], x} - {prev_q[31], prev_q};
		hit       = (rdata_q >= x) || ({1'b0, i_q} == cnt - 5'd1);
		div_start = (state_q == L_SCAN) && hit && !gap_w[32] && (gap_w != '0);
		case (state_q)
			L_FIRST: rd_addr = {d_q, nm1};
			L_LAST:  rd_addr = {d_q, 4'd1};
			L_SCAN:  rd_addr = {d_q, 4'(i_q + 4'd1)};
			default: rd_addr = {d_q, 4'd0};
		endcase
	end

	// Breakpoint memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (bp_we)
			bp_mem[bp_waddr] <= bp_wdata;
		rdata_q <= bp_mem[rd_addr];
	end

	mti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dx     (dx_w[31:0]),
		.gap    (gap_w[31:0]),
		.done   (div_done),
		.quot   (div_q)
	);

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			d_q     <= '0;
			i_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						d_q     <= '0;
						state_q <= L_DIM;
					end
				end
				L_DIM: begin
					if (d_q >= cfg.num_dims) begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end else if (cnt == 5'd0) begin
						lo_q[d_q] <= '0;
						fr_q[d_q] <= '0;
						d_q       <= d_q + 3'd1;
					end else begin
						state_q <= L_FIRST;
					end
				end
				L_FIRST: begin
					// at or below the first breakpoint
					if (x <= rdata_q) begin
						lo_q[d_q] <= '0;
						fr_q[d_q] <= '0;
						d_q       <= d_q + 3'd1;
						state_q   <= L_DIM;
					end else begin
						prev_q  <= rdata_q;
						state_q <= L_LAST;
					end
				end
				L_LAST: begin
					// at or above the last breakpoint
					if (x >= rdata_q) begin
						lo_q[d_q] <= (cnt > 5'd1) ? 4'(cnt - 5'd2) : 4'd0;
						fr_q[d_q] <= mti_pkg::FRAC_ONE;
						d_q       <= d_q + 3'd1;
						state_q   <= L_DIM;
					end else begin
						i_q     <= 4'd1;
						state_q <= L_SCAN;
					end
				end
				L_SCAN: begin
					if (hit) begin
						lo_q[d_q] <= 4'(i_q - 4'd1);
						if (div_start) begin
							state_q <= L_DIV;
						end else begin
							fr_q[d_q] <= '0;
							d_q       <= d_q + 3'd1;
							state_q   <= L_DIM;
						end
					end else begin
						prev_q <= rdata_q;
						i_q    <= i_q + 4'd1;
					end
				end
				L_DIV: begin
					if (div_done) begin
						fr_q[d_q] <= div_q;
						d_q       <= d_q + 3'd1;
						state_q   <= L_DIM;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign lo_vec = lo_q;
	assign fr_vec = fr_q;

	`MTI_ASSERT_NOW(a_scan_pos, state_q == L_SCAN,
		(i_q != 4'd0) && ({1'b0, i_q} <= cnt - 5'd1))
	`MTI_ASSERT_NOW(a_scan_prev_below, state_q == L_SCAN, x > prev_q)
	`MTI_ASSERT_NOW(a_div_owner, div_done, state_q == L_DIV)

endmodule

/* sv/mti_corner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_corner
// Grid memory and corner walk: weights, flat index, accumulate, round.
// ----------------------------------------------------------------------------
`include "multilinear_table_interp_defines.svh"

module mti_corner (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 grid_we,
	input  logic [11:0]          grid_waddr,
	input  logic signed [31:0]   grid_wdata,
	input  logic                 start,
	input  mti_pkg::cfg_t        cfg,
	input  mti_pkg::lo_vec_t     lo_vec,
	input  mti_pkg::fr_vec_t     fr_vec,
	input  logic                 res_take,
	output logic                 res_valid,
	output mti_pkg::out_item_t   res
);

	typedef enum logic [2:0] {
		C_IDLE, C_DIM, C_READ, C_MUL, C_ACC, C_ROUND, C_HOLD
	} cstate_t;

	cstate_t              state_q;
	logic [6:0]           corner_q;
	logic [2:0]           d_q;
	logic [16:0]          w_q;
	logic [24:0]          flat_q;
	logic [24:0]          stride_q;
	logic signed [49:0]   prod_s1;
	logic signed [55:0]   acc_q;
	mti_pkg::out_item_t   res_q;

	logic signed [31:0]   grid_mem [mti_pkg::GRID_DEPTH];
	logic signed [31:0]   rdata_q;

	logic                 bit_sel;
	logic [4:0]           cnt;
	logic [3:0]           lo_d;
	logic [3:0]           maxi;
	logic [4:0]           kp1;
	logic [3:0]           k;
	logic [16:0]          f;
	logic [33:0]          wprod;
	logic                 last_corner;
	logic                 in_range;
	logic                 rd_en;
	logic signed [55:0]   rsum;
	logic signed [39:0]   q;
	logic                 fits;

	// One dimension step of the current corner
	always_comb begin
		bit_sel = corner_q[d_q];
		cnt     = cfg.bp_count[d_q];
		lo_d    = lo_vec[d_q];
		maxi    = (cnt == 5'd0) ? 4'd0 : 4'(cnt - 5'd1);
		kp1     = {1'b0, lo_d} + 5'd1;
		if (bit_sel) begin
			k = (kp1 > {1'b0, maxi}) ? maxi : kp1[3:0];
			f = fr_vec[d_q];
		end else begin
			k = lo_d;
			f = mti_pkg::FRAC_ONE - fr_vec[d_q];
		end
		wprod       = w_q * f;
		last_corner = corner_q == 7'((7'd1 << cfg.num_dims) - 7'd1);
		in_range    = flat_q < {12'd0, cfg.data_count};
		rd_en       = (state_q == C_READ) && in_range;
		// round half up, then clip to 32 bits
		rsum        = acc_q + 56'sd32768;
		q           = rsum[55:16];
		fits        = (q[39:31] == '0) || (q[39:31] == '1);
	end

	// Grid memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (grid_we)
			grid_mem[grid_waddr] <= grid_wdata;
		if (rd_en)
			rdata_q <= grid_mem[flat_q[11:0]];
	end

	// Corner sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						acc_q    <= '0;
						corner_q <= '0;
						d_q      <= 3'(cfg.num_dims - 3'd1);
						w_q      <= mti_pkg::FRAC_ONE;
						flat_q   <= '0;
						stride_q <= 25'd1;
						if (cfg.num_dims == 3'd0 || cfg.data_count == 13'd0) begin
							res_q   <= '0;
							state_q <= C_HOLD;
						end else begin
							state_q <= C_DIM;
						end
					end
				end
				C_DIM: begin
					w_q      <= wprod[32:16];
					flat_q   <= flat_q + 25'(k * stride_q);
					stride_q <= 25'(stride_q * cnt);
					if (d_q == 3'd0)
						state_q <= C_READ;
					else
						d_q <= d_q - 3'd1;
				end
				C_READ: begin
					if (in_range) begin
						state_q <= C_MUL;
					end else if (last_corner) begin
						state_q <= C_ROUND;
					end else begin
						corner_q <= corner_q + 7'd1;
						d_q      <= 3'(cfg.num_dims - 3'd1);
						w_q      <= mti_pkg::FRAC_ONE;
						flat_q   <= '0;
						stride_q <= 25'd1;
						state_q  <= C_DIM;
					end
				end
				C_MUL: begin
					prod_s1 <= $signed({1'b0, w_q}) * rdata_q;
					state_q <= C_ACC;
				end
				C_ACC: begin
					acc_q <= acc_q + 56'(prod_s1);
					if (last_corner) begin
						state_q <= C_ROUND;
					end else begin
						corner_q <= corner_q + 7'd1;
						d_q      <= 3'(cfg.num_dims - 3'd1);
						w_q      <= mti_pkg::FRAC_ONE;
						flat_q   <= '0;
						stride_q <= 25'd1;
						state_q  <= C_DIM;
					end
				end
				C_ROUND: begin
					res_q.saturated <= !fits;
					if (fits)
						res_q.interp_value <= q[31:0];
					else if (q[39])
						res_q.interp_value <= 32'sh8000_0000;
					else
						res_q.interp_value <= 32'sh7fff_ffff;
					state_q <= C_HOLD;
				end
				C_HOLD: begin
					if (res_take)
						state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign res_valid = state_q == C_HOLD;
	assign res       = res_q;

	`MTI_ASSERT_NOW(a_dim_active, state_q == C_DIM, d_q < cfg.num_dims)
	`MTI_ASSERT_NOW(a_weight_range, state_q == C_DIM, w_q <= mti_pkg::FRAC_ONE)
	`MTI_ASSERT_NEXT(a_read_to_mul, (state_q == C_READ) && in_range, state_q == C_MUL)

endmodule

/* sv/multilinear_table_interp.sv */
`timescale 1ns / 1ps
// Table writes are accepted every cycle while no lookup is in progress.
// A lookup searches the breakpoints of each dimension, dividing where a point falls
// inside an interval, then walks the 2^num_dims grid corners, weighting and accumulating.
// One lookup at a time; in_stall holds all input items until its result is taken.
// Reset clears configuration and control; table memories are undefined until written.
// ----------------------------------------------------------------------------
// multilinear_table_interp
// Multilinear interpolation table over up to six dimensions in Q16.16.
// ----------------------------------------------------------------------------
module multilinear_table_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [12:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  mti_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mti_pkg::out_item_t  out_data
);

	mti_pkg::cfg_t       cfg_q;
	logic                busy_q;
	logic                start_q;
	mti_pkg::coord_vec_t coord_q;
	logic                out_valid_q;
	mti_pkg::out_item_t  out_data_q;

	logic                in_acc;
	logic                bp_we;
	logic                grid_we;
	logic                loc_done;
	mti_pkg::lo_vec_t    lo_vec;
	mti_pkg::fr_vec_t    fr_vec;
	logic                res_valid;
	logic                res_take;
	mti_pkg::out_item_t  res;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign bp_we    = in_acc && (in_data.action == mti_pkg::ACT_BP_WR)
		&& (in_data.dim < 3'(mti_pkg::MAX_DIMS))
		&& (in_data.index < 12'(mti_pkg::MAX_BP));
	assign grid_we  = in_acc && (in_data.action == mti_pkg::ACT_GRID_WR);
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	// Configuration registers, stored already saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mti_pkg::REG_NUM_DIMS:
					cfg_q.num_dims <= (cfg_data[2:0] > 3'(mti_pkg::MAX_DIMS))
						? 3'(mti_pkg::MAX_DIMS) : cfg_data[2:0];
				mti_pkg::REG_DATA_COUNT:
					cfg_q.data_count <= (cfg_data > 13'(mti_pkg::GRID_DEPTH))
						? 13'(mti_pkg::GRID_DEPTH) : cfg_data;
				default:
					cfg_q.bp_count[cfg_index - mti_pkg::REG_BP_COUNT_0] <=
						(cfg_data[4:0] > 5'(mti_pkg::MAX_BP))
						? 5'(mti_pkg::MAX_BP) : cfg_data[4:0];
			endcase
		end
	end

	// Lookup control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (in_acc && in_data.action == mti_pkg::ACT_LOOKUP) begin
				busy_q  <= 1'b1;
				start_q <= 1'b1;
			end else if (res_take) begin
				busy_q <= 1'b0;
			end
			if (res_take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.action == mti_pkg::ACT_LOOKUP)
			coord_q <= {in_data.coord_5, in_data.coord_4, in_data.coord_3,
				in_data.coord_2, in_data.coord_1, in_data.coord_0};
		if (res_take)
			out_data_q <= res;
	end

	mti_locate u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.bp_we    (bp_we),
		.bp_waddr ({in_data.dim, in_data.index[3:0]}),
		.bp_wdata (in_data.value),
		.start    (start_q),
		.cfg      (cfg_q),
		.coords   (coord_q),
		.done     (loc_done),
		.lo_vec   (lo_vec),
		.fr_vec   (fr_vec)
	);

	mti_corner u_corner (
		.clk        (clk),
		.arst_n     (arst_n),
		.grid_we    (grid_we),
		.grid_waddr (in_data.index),
		.grid_wdata (in_data.value),
		.start      (loc_done),
		.cfg        (cfg_q),
		.lo_vec     (lo_vec),
		.fr_vec     (fr_vec),
		.res_take   (res_take),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
